>>> hw/rtl/i2c_master_bit_engine_defines.svh
// Assertion helpers for the I2C master bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define I2CM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c master: assertion failed");

// Next-cycle implication, checked outside reset.
`define I2CM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c master: assertion failed");

`else

`define I2CM_ASSERT_IMP(label, ante, cons)
`define I2CM_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

    localparam int COUNTER_BITS_DEF = 8;
    localparam int PADDR_BITS       = 5;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_HI,
        PH_ST_SDA,
        PH_WR_LOW,
        PH_WR_HIGH,
        PH_WR_FALL,
        PH_WA_REL,
        PH_WA_CLK,
        PH_WA_POLL,
        PH_RD_LOW,
        PH_RD_HIGH,
        PH_AK_LOW,
        PH_AK_HIGH,
        PH_SP_LOW,
        PH_SP_CLK,
        PH_SP_REL
    } phase_t;

    localparam logic [2:0] CMD_START_WR = 3'd0;
    localparam logic [2:0] CMD_START_RD = 3'd1;
    localparam logic [2:0] CMD_WRITE    = 3'd2;
    localparam logic [2:0] CMD_READ     = 3'd3;
    localparam logic [2:0] CMD_STOP     = 3'd4;

    localparam logic [2:0] REG_SLAVE_ADDR  = 3'd0;
    localparam logic [2:0] REG_SETUP       = 3'd1;
    localparam logic [2:0] REG_BIT_HALF    = 3'd2;
    localparam logic [2:0] REG_ACK_SETTLE  = 3'd3;
    localparam logic [2:0] REG_ACK_TIMEOUT = 3'd4;

    localparam logic [6:0] SLAVE_ADDR_RST  = 7'd127;
    localparam logic [7:0] SETUP_RST       = 8'd4;
    localparam logic [7:0] BIT_HALF_RST    = 8'd2;
    localparam logic [7:0] ACK_SETTLE_RST  = 8'd1;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd200;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       req_type;
        logic [2:0] command;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       no_ack;
        logic [7:0] read_data;
        logic       rejected;
    } res_t;

endpackage

>>> hw/rtl/i2c_master_bit_engine.sv
// Byte-level I2C master. Each beat on the item channel is either a tick (carrying the
// sampled SDA level) or a command (start+address write/read, write byte, read byte with
// ACK/NACK, stop); commands are taken only while idle, otherwise flagged rejected. Every
// item yields exactly one result beat with the SCL/SDA drive levels and status after
// that item. An item is accepted in every cycle in which the result register is empty
// or being drained, so throughput is one item per clock, and its result beat is valid
// in the next cycle: the phase machine update is a single combinational step into the
// result register. Bit timing is counted in ticks set by the APB registers; an
// acknowledge still missing once the poll count reaches ack_timeout ends the command with a stop and no_ack set.
`include "i2c_master_bit_engine_defines.svh"

module i2c_master_bit_engine #(
    parameter int COUNTER_BITS = i2cm_pkg::COUNTER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  i2cm_pkg::req_t                  item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output i2cm_pkg::res_t                  result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [i2cm_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int CB = COUNTER_BITS;
    localparam int WW = (CB > 8) ? CB : 8;
    localparam logic [WW-1:0] CNT_MAX = WW'((64'd1 << CB) - 64'd1);

    // delay load: zero counts as one, large values saturate
    function automatic logic [CB-1:0] sat_count(input logic [7:0] v);
        logic [WW-1:0] w;
        begin
            w = WW'(v);
            if (v == 8'd0)
            begin
                w = WW'(1);
            end
            if (w > CNT_MAX)
            begin
                w = CNT_MAX;
            end
            return w[CB-1:0];
        end
    endfunction

    function automatic logic [WW-1:0] clamp_count(input logic [7:0] v);
        logic [WW-1:0] w;
        begin
            w = WW'(v);
            if (w > CNT_MAX)
            begin
                w = CNT_MAX;
            end
            return w;
        end
    endfunction

    // configuration registers
    logic [6:0] slave_address_reg;
    logic [7:0] setup_ticks_reg;
    logic [7:0] bit_half_ticks_reg;
    logic [7:0] ack_settle_ticks_reg;
    logic [7:0] ack_timeout_reg;

    // engine state
    i2cm_pkg::phase_t phase_reg, phase_next;
    logic [CB-1:0]    tick_count_reg, tick_count_next;
    logic [3:0]       bit_index_reg, bit_index_next;
    logic [7:0]       shift_byte_reg, shift_byte_next;
    logic [CB-1:0]    poll_count_reg, poll_count_next;
    logic             scl_level_reg, scl_level_next;
    logic             sda_level_reg, sda_level_next;
    logic             ack_choice_reg, ack_choice_next;
    logic [2:0]       active_command_reg, active_command_next;
    logic [7:0]       read_hold_reg, read_hold_next;

    logic           result_valid_reg;
    i2cm_pkg::res_t result_reg;

    logic             item_accept;
    logic             cfg_write;
    logic [2:0]       cfg_index;
    logic             go_enter;
    i2cm_pkg::phase_t enter_phase;
    logic             cmd_ok;
    logic             tick_dec;
    logic             tick_end;
    logic             poll_inc;
    logic             ack_seen;
    logic             wr_shift;
    logic             rd_shift;
    logic             read_finish;
    logic             done;
    logic             fail;
    logic             rej;

    assign item_ready  = !result_valid_reg || result_ready;
    assign item_accept = item_valid && item_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg    <= i2cm_pkg::SLAVE_ADDR_RST;
            setup_ticks_reg      <= i2cm_pkg::SETUP_RST;
            bit_half_ticks_reg   <= i2cm_pkg::BIT_HALF_RST;
            ack_settle_ticks_reg <= i2cm_pkg::ACK_SETTLE_RST;
            ack_timeout_reg      <= i2cm_pkg::ACK_TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                i2cm_pkg::REG_SLAVE_ADDR:  slave_address_reg    <= pwdata[6:0];
                i2cm_pkg::REG_SETUP:       setup_ticks_reg      <= pwdata[7:0];
                i2cm_pkg::REG_BIT_HALF:    bit_half_ticks_reg   <= pwdata[7:0];
                i2cm_pkg::REG_ACK_SETTLE:  ack_settle_ticks_reg <= pwdata[7:0];
                i2cm_pkg::REG_ACK_TIMEOUT: ack_timeout_reg      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            i2cm_pkg::REG_SLAVE_ADDR:  prdata = {25'd0, slave_address_reg};
            i2cm_pkg::REG_SETUP:       prdata = {24'd0, setup_ticks_reg};
            i2cm_pkg::REG_BIT_HALF:    prdata = {24'd0, bit_half_ticks_reg};
            i2cm_pkg::REG_ACK_SETTLE:  prdata = {24'd0, ack_settle_ticks_reg};
            i2cm_pkg::REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // next phase and step decisions
    always_comb
    begin
        go_enter    = 1'b0;
        enter_phase = i2cm_pkg::PH_IDLE;
        phase_next  = phase_reg;
        cmd_ok      = 1'b0;
        tick_dec    = 1'b0;
        tick_end    = 1'b0;
        poll_inc    = 1'b0;
        ack_seen    = 1'b0;
        wr_shift    = 1'b0;
        rd_shift    = 1'b0;
        read_finish = 1'b0;
        done        = 1'b0;
        fail        = 1'b0;
        rej         = 1'b0;
        if (item_accept)
        begin
            if (item.req_type)
            begin
                if (phase_reg != i2cm_pkg::PH_IDLE || item.command > i2cm_pkg::CMD_STOP)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    cmd_ok   = 1'b1;
                    go_enter = 1'b1;
                    priority case (item.command)
                        i2cm_pkg::CMD_START_WR,
                        i2cm_pkg::CMD_START_RD: enter_phase = i2cm_pkg::PH_ST_HI;
                        i2cm_pkg::CMD_WRITE:    enter_phase = i2cm_pkg::PH_WR_LOW;
                        i2cm_pkg::CMD_READ:     enter_phase = i2cm_pkg::PH_RD_LOW;
                        default:                enter_phase = i2cm_pkg::PH_SP_LOW;
                    endcase
                end
            end
            else if (phase_reg == i2cm_pkg::PH_WA_POLL)
            begin
                if (!item.sda_in)
                begin
                    ack_seen   = 1'b1;
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                else if (WW'(poll_count_reg) >= clamp_count(ack_timeout_reg))
                begin
                    go_enter    = 1'b1;
                    enter_phase = i2cm_pkg::PH_SP_LOW;
                end
                else
                begin
                    poll_inc = 1'b1;
                end
            end
            else if (phase_reg != i2cm_pkg::PH_IDLE)
            begin
                if (tick_count_reg > CB'(1))
                begin
                    tick_dec = 1'b1;
                end
                else
                begin
                    tick_end = 1'b1;
                    go_enter = 1'b1;
                    unique case (phase_reg)
                        i2cm_pkg::PH_ST_HI:   enter_phase = i2cm_pkg::PH_ST_SDA;
                        i2cm_pkg::PH_ST_SDA:  enter_phase = i2cm_pkg::PH_WR_LOW;
                        i2cm_pkg::PH_WR_LOW:  enter_phase = i2cm_pkg::PH_WR_HIGH;
                        i2cm_pkg::PH_WR_HIGH: enter_phase = i2cm_pkg::PH_WR_FALL;
                        i2cm_pkg::PH_WR_FALL:
                        begin
                            wr_shift    = 1'b1;
                            enter_phase = (bit_index_reg + 4'd1 < i2cm_pkg::BITS_PER_BYTE)
                                        ? i2cm_pkg::PH_WR_LOW : i2cm_pkg::PH_WA_REL;
                        end
                        i2cm_pkg::PH_WA_REL:  enter_phase = i2cm_pkg::PH_WA_CLK;
                        i2cm_pkg::PH_WA_CLK:  enter_phase = i2cm_pkg::PH_WA_POLL;
                        i2cm_pkg::PH_RD_LOW:  enter_phase = i2cm_pkg::PH_RD_HIGH;
                        i2cm_pkg::PH_RD_HIGH:
                        begin
                            rd_shift    = 1'b1;
                            enter_phase = (bit_index_reg + 4'd1 < i2cm_pkg::BITS_PER_BYTE)
                                        ? i2cm_pkg::PH_RD_LOW : i2cm_pkg::PH_AK_LOW;
                        end
                        i2cm_pkg::PH_AK_LOW:  enter_phase = i2cm_pkg::PH_AK_HIGH;
                        i2cm_pkg::PH_AK_HIGH:
                        begin
                            go_enter    = 1'b0;
                            read_finish = 1'b1;
                            phase_next  = i2cm_pkg::PH_IDLE;
                            done        = 1'b1;
                        end
                        i2cm_pkg::PH_SP_LOW:  enter_phase = i2cm_pkg::PH_SP_CLK;
                        i2cm_pkg::PH_SP_CLK:  enter_phase = i2cm_pkg::PH_SP_REL;
                        i2cm_pkg::PH_SP_REL:
                        begin
                            go_enter   = 1'b0;
                            phase_next = i2cm_pkg::PH_IDLE;
                            done       = 1'b1;
                            fail       = (active_command_reg != i2cm_pkg::CMD_STOP);
                        end
                        default:
                        begin
                            go_enter   = 1'b0;
                            phase_next = i2cm_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            if (go_enter)
            begin
                phase_next = enter_phase;
            end
        end
    end

    // datapath and line levels
    always_comb
    begin
        tick_count_next     = tick_count_reg;
        bit_index_next      = bit_index_reg;
        shift_byte_next     = shift_byte_reg;
        poll_count_next     = poll_count_reg;
        scl_level_next      = scl_level_reg;
        sda_level_next      = sda_level_reg;
        ack_choice_next     = ack_choice_reg;
        active_command_next = active_command_reg;
        read_hold_next      = read_hold_reg;

        if (cmd_ok)
        begin
            active_command_next = item.command;
            bit_index_next      = 4'd0;
            poll_count_next     = '0;
            if (item.command == i2cm_pkg::CMD_START_WR || item.command == i2cm_pkg::CMD_START_RD)
            begin
                shift_byte_next = {slave_address_reg, item.command[0]};
            end
            else if (item.command == i2cm_pkg::CMD_WRITE)
            begin
                shift_byte_next = item.write_data;
            end
            else if (item.command == i2cm_pkg::CMD_READ)
            begin
                shift_byte_next = 8'd0;
                ack_choice_next = item.send_ack;
            end
        end
        if (tick_dec)
        begin
            tick_count_next = tick_count_reg - CB'(1);
        end
        if (tick_end)
        begin
            tick_count_next = '0;
        end
        if (poll_inc)
        begin
            poll_count_next = poll_count_reg + CB'(1);
        end
        if (wr_shift)
        begin
            shift_byte_next = {shift_byte_reg[6:0], 1'b0};
            bit_index_next  = bit_index_reg + 4'd1;
        end
        if (rd_shift)
        begin
            shift_byte_next = {shift_byte_reg[6:0], item.sda_in};
            bit_index_next  = bit_index_reg + 4'd1;
        end
        if (ack_seen)
        begin
            scl_level_next = 1'b0;
        end
        if (read_finish)
        begin
            scl_level_next = 1'b0;
            read_hold_next = shift_byte_reg;
        end

        if (go_enter)
        begin
            tick_count_next = '0;
            unique case (enter_phase)
                i2cm_pkg::PH_ST_HI:
                begin
                    sda_level_next  = 1'b1;
                    scl_level_next  = 1'b1;
                    tick_count_next = sat_count(setup_ticks_reg);
                end
                i2cm_pkg::PH_ST_SDA:
                begin
                    sda_level_next  = 1'b0;
                    tick_count_next = sat_count(setup_ticks_reg);
                end
                i2cm_pkg::PH_WR_LOW:
                begin
                    scl_level_next  = 1'b0;
                    sda_level_next  = shift_byte_next[7];
                    tick_count_next = sat_count(bit_half_ticks_reg);
                end
                i2cm_pkg::PH_WR_HIGH,
                i2cm_pkg::PH_RD_HIGH,
                i2cm_pkg::PH_AK_HIGH:
                begin
                    scl_level_next  = 1'b1;
                    tick_count_next = sat_count(bit_half_ticks_reg);
                end
                i2cm_pkg::PH_WR_FALL:
                begin
                    scl_level_next  = 1'b0;
                    tick_count_next = sat_count(bit_half_ticks_reg);
                end
                i2cm_pkg::PH_WA_REL:
                begin
                    sda_level_next  = 1'b1;
                    tick_count_next = sat_count(ack_settle_ticks_reg);
                end
                i2cm_pkg::PH_WA_CLK:
                begin
                    scl_level_next  = 1'b1;
                    tick_count_next = sat_count(ack_settle_ticks_reg);
                end
                i2cm_pkg::PH_WA_POLL:
                begin
                    poll_count_next = '0;
                end
                i2cm_pkg::PH_RD_LOW:
                begin
                    scl_level_next  = 1'b0;
                    sda_level_next  = 1'b1;
                    tick_count_next = sat_count(bit_half_ticks_reg);
                end
                i2cm_pkg::PH_AK_LOW:
                begin
                    scl_level_next  = 1'b0;
                    sda_level_next  = !ack_choice_next;
                    tick_count_next = sat_count(bit_half_ticks_reg);
                end
                i2cm_pkg::PH_SP_LOW:
                begin
                    scl_level_next  = 1'b0;
                    sda_level_next  = 1'b0;
                    tick_count_next = sat_count(setup_ticks_reg);
                end
                i2cm_pkg::PH_SP_CLK:
                begin
                    scl_level_next  = 1'b1;
                    tick_count_next = sat_count(setup_ticks_reg);
                end
                i2cm_pkg::PH_SP_REL:
                begin
                    sda_level_next  = 1'b1;
                    tick_count_next = sat_count(setup_ticks_reg);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= i2cm_pkg::PH_IDLE;
            tick_count_reg     <= '0;
            bit_index_reg      <= 4'd0;
            shift_byte_reg     <= 8'd0;
            poll_count_reg     <= '0;
            scl_level_reg      <= 1'b1;
            sda_level_reg      <= 1'b1;
            ack_choice_reg     <= 1'b0;
            active_command_reg <= i2cm_pkg::CMD_START_WR;
            read_hold_reg      <= 8'd0;
        end
        else if (item_accept)
        begin
            phase_reg          <= phase_next;
            tick_count_reg     <= tick_count_next;
            bit_index_reg      <= bit_index_next;
            shift_byte_reg     <= shift_byte_next;
            poll_count_reg     <= poll_count_next;
            scl_level_reg      <= scl_level_next;
            sda_level_reg      <= sda_level_next;
            ack_choice_reg     <= ack_choice_next;
            active_command_reg <= active_command_next;
            read_hold_reg      <= read_hold_next;
        end
    end

    // result register: one beat per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            result_reg.scl_out   <= scl_level_next;
            result_reg.sda_out   <= sda_level_next;
            result_reg.busy_res  <= (phase_next != i2cm_pkg::PH_IDLE);
            result_reg.done_res  <= done;
            result_reg.no_ack    <= fail;
            result_reg.read_data <= read_hold_next;
            result_reg.rejected  <= rej;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `I2CM_ASSERT_IMP(a_noack_done, result_valid_reg && result_reg.no_ack, result_reg.done_res)
    `I2CM_ASSERT_IMP(a_done_idle, result_valid_reg && result_reg.done_res, !result_reg.busy_res)
    `I2CM_ASSERT_IMP(a_rej_quiet, result_valid_reg && result_reg.rejected, !result_reg.done_res)
    `I2CM_ASSERT_NXT(a_cmd_starts, item_accept && item.req_type && phase_reg == i2cm_pkg::PH_IDLE && item.command <= i2cm_pkg::CMD_STOP, phase_reg != i2cm_pkg::PH_IDLE)
    `I2CM_ASSERT_IMP(a_bit_range, 1'b1, bit_index_reg <= i2cm_pkg::BITS_PER_BYTE)

endmodule

>>> test/tb_i2c_master_bit_engine.sv
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT         = 1000000;
    localparam int CNT_MAX             = (1 << COUNTER_BITS_DEF) - 1;
    localparam int CMD_CODE_MAX        = 7;
    localparam int RAND_ITEMS_PER_SET  = 150;
    localparam int SETTLE_CYCLES       = 8;
    localparam int MAX_PRINTED         = 40;
    localparam logic [2:0] REG_UNUSED    = 3'd5;
    localparam logic [2:0] REG_LAST_CODE = 3'd7;

    typedef enum int { LINE_RANDOM, LINE_HIGH, LINE_LOW } line_mode_t;

    // Tracks the engine's bus state and holds the result beats still due.
    class i2c_line_model;
        phase_t      ph;
        int          tick_cnt;
        int          polls;
        logic [3:0]  bit_idx;
        logic [7:0]  shreg;
        logic        scl;
        logic        sda;
        logic        ack_sel;
        logic [2:0]  cur_cmd;
        logic [7:0]  rx_byte;
        logic [6:0]  addr_r;
        logic [7:0]  setup_r;
        logic [7:0]  half_r;
        logic [7:0]  settle_r;
        logic [7:0]  tmo_r;
        res_t        pending_res[$];
        bit          last_fail;
        int          n_err;
        int          n_checked;
        int          n_live;
        int          n_done;
        int          n_noack;
        int          n_rej;

        function new();
            ph       = PH_IDLE;
            tick_cnt = 0;
            polls    = 0;
            bit_idx  = '0;
            shreg    = '0;
            scl      = 1'b1;
            sda      = 1'b1;
            ack_sel  = 1'b0;
            cur_cmd  = '0;
            rx_byte  = '0;
            addr_r   = SLAVE_ADDR_RST;
            setup_r  = SETUP_RST;
            half_r   = BIT_HALF_RST;
            settle_r = ACK_SETTLE_RST;
            tmo_r    = ACK_TIMEOUT_RST;
        endfunction

        function void report(string msg);
            n_err++;
            if (n_err <= MAX_PRINTED)
                $display("[%0t] MISMATCH %s", $realtime, msg);
        endfunction

        function void cmp(string what, int got, int want);
            if (got != want)
                report($sformatf("%s: got %0d, expected %0d", what, got, want));
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_SLAVE_ADDR:  addr_r   = d[6:0];
                REG_SETUP:       setup_r  = d[7:0];
                REG_BIT_HALF:    half_r   = d[7:0];
                REG_ACK_SETTLE:  settle_r = d[7:0];
                REG_ACK_TIMEOUT: tmo_r    = d[7:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                REG_SLAVE_ADDR:  return {25'd0, addr_r};
                REG_SETUP:       return {24'd0, setup_r};
                REG_BIT_HALF:    return {24'd0, half_r};
                REG_ACK_SETTLE:  return {24'd0, settle_r};
                default:         return {24'd0, tmo_r};
            endcase
        endfunction

        // zero counts as one tick, anything wider than the counter saturates
        function int span(logic [7:0] v);
            int n;
            n = v;
            if (n == 0)
                n = 1;
            if (n > CNT_MAX)
                n = CNT_MAX;
            return n;
        endfunction

        function void go_to(phase_t p);
            ph       = p;
            tick_cnt = 0;
            case (p)
                PH_ST_HI:
                begin
                    sda = 1'b1; scl = 1'b1; tick_cnt = span(setup_r);
                end
                PH_ST_SDA:  begin sda = 1'b0; tick_cnt = span(setup_r); end
                PH_WR_LOW:
                begin
                    scl = 1'b0; sda = shreg[7]; tick_cnt = span(half_r);
                end
                PH_WR_HIGH: begin scl = 1'b1; tick_cnt = span(half_r); end
                PH_WR_FALL: begin scl = 1'b0; tick_cnt = span(half_r); end
                PH_WA_REL:  begin sda = 1'b1; tick_cnt = span(settle_r); end
                PH_WA_CLK:  begin scl = 1'b1; tick_cnt = span(settle_r); end
                PH_WA_POLL: polls = 0;
                PH_RD_LOW:
                begin
                    scl = 1'b0; sda = 1'b1; tick_cnt = span(half_r);
                end
                PH_RD_HIGH: begin scl = 1'b1; tick_cnt = span(half_r); end
                PH_AK_LOW:
                begin
                    scl = 1'b0; sda = ~ack_sel; tick_cnt = span(half_r);
                end
                PH_AK_HIGH: begin scl = 1'b1; tick_cnt = span(half_r); end
                PH_SP_LOW:
                begin
                    scl = 1'b0; sda = 1'b0; tick_cnt = span(setup_r);
                end
                PH_SP_CLK:  begin scl = 1'b1; tick_cnt = span(setup_r); end
                PH_SP_REL:  begin sda = 1'b1; tick_cnt = span(setup_r); end
                default:    ph = PH_IDLE;
            endcase
        endfunction

        // Called once per accepted item beat; queues the result beat it causes.
        function void take_item(req_t r);
            res_t want;
            bit   fin;
            bit   fail;
            bit   rej;
            bit   live;
            fin  = 1'b0;
            fail = 1'b0;
            rej  = 1'b0;
            live = 1'b1;
            if (r.req_type)
            begin
                if (ph != PH_IDLE || r.command > CMD_STOP)
                begin
                    rej  = 1'b1;
                    live = 1'b0;
                end
                else
                begin
                    cur_cmd = r.command;
                    bit_idx = '0;
                    polls   = 0;
                    case (r.command)
                        CMD_START_WR, CMD_START_RD:
                        begin
                            shreg = {addr_r, r.command[0]};
                            go_to(PH_ST_HI);
                        end
                        CMD_WRITE:
                        begin
                            shreg = r.write_data;
                            go_to(PH_WR_LOW);
                        end
                        CMD_READ:
                        begin
                            shreg   = '0;
                            ack_sel = r.send_ack;
                            go_to(PH_RD_LOW);
                        end
                        default: go_to(PH_SP_LOW);
                    endcase
                end
            end
            else if (ph == PH_WA_POLL)
            begin
                if (!r.sda_in)
                begin
                    scl = 1'b0;
                    ph  = PH_IDLE;
                    fin = 1'b1;
                end
                else if (polls >= tmo_r)
                    go_to(PH_SP_LOW);
                else
                    polls++;
            end
            else if (ph != PH_IDLE)
            begin
                if (tick_cnt > 1)
                    tick_cnt--;
                else
                begin
                    tick_cnt = 0;
                    case (ph)
                        PH_ST_HI:   go_to(PH_ST_SDA);
                        PH_ST_SDA:
                        begin
                            bit_idx = '0;
                            go_to(PH_WR_LOW);
                        end
                        PH_WR_LOW:  go_to(PH_WR_HIGH);
                        PH_WR_HIGH: go_to(PH_WR_FALL);
                        PH_WR_FALL:
                        begin
                            shreg = shreg << 1;
                            bit_idx++;
                            go_to(bit_idx < BITS_PER_BYTE ? PH_WR_LOW : PH_WA_REL);
                        end
                        PH_WA_REL:  go_to(PH_WA_CLK);
                        PH_WA_CLK:  go_to(PH_WA_POLL);
                        PH_RD_LOW:  go_to(PH_RD_HIGH);
                        PH_RD_HIGH:
                        begin
                            shreg = {shreg[6:0], r.sda_in};
                            bit_idx++;
                            go_to(bit_idx < BITS_PER_BYTE ? PH_RD_LOW : PH_AK_LOW);
                        end
                        PH_AK_LOW:  go_to(PH_AK_HIGH);
                        PH_AK_HIGH:
                        begin
                            scl     = 1'b0;
                            rx_byte = shreg;
                            ph      = PH_IDLE;
                            fin     = 1'b1;
                        end
                        PH_SP_LOW:  go_to(PH_SP_CLK);
                        PH_SP_CLK:  go_to(PH_SP_REL);
                        PH_SP_REL:
                        begin
                            fail = (cur_cmd != CMD_STOP);
                            ph   = PH_IDLE;
                            fin  = 1'b1;
                        end
                        default:    ph = PH_IDLE;
                    endcase
                end
            end
            else
                live = 1'b0;

            if (fin)
            begin
                last_fail = fail;
                n_done++;
            end
            if (fail)
                n_noack++;
            if (rej)
                n_rej++;
            if (live)
                n_live++;

            want.scl_out   = scl;
            want.sda_out   = sda;
            want.busy_res  = (ph != PH_IDLE);
            want.done_res  = fin;
            want.no_ack    = fail;
            want.read_data = rx_byte;
            want.rejected  = rej;
            pending_res.push_back(want);
        endfunction

        function void check_beat(res_t got);
            res_t  want;
            string tag;
            if (pending_res.size() == 0)
            begin
                report("result beat with nothing outstanding");
                return;
            end
            want = pending_res.pop_front();
            n_checked++;
            tag = $sformatf("beat %0d", n_checked);
            cmp({tag, " scl_out"},   got.scl_out,   want.scl_out);
            cmp({tag, " sda_out"},   got.sda_out,   want.sda_out);
            cmp({tag, " busy_res"},  got.busy_res,  want.busy_res);
            cmp({tag, " done_res"},  got.done_res,  want.done_res);
            cmp({tag, " no_ack"},    got.no_ack,    want.no_ack);
            cmp({tag, " read_data"}, got.read_data, want.read_data);
            cmp({tag, " rejected"},  got.rejected,  want.rejected);
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    req_t                  item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    res_t                  result;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [PADDR_BITS-1:0] paddr        = '0;
    logic [31:0]           pwdata       = '0;
    logic [31:0]           prdata;
    logic                  pready;

    i2c_line_model mdl = new();
    int            send_idle = 0;
    int            recv_idle = 0;
    int            n_cycles  = 0;
    bit            slave_gone = 1'b0;
    line_mode_t    line_mode  = LINE_RANDOM;

    i2c_master_bit_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
            mdl.check_beat(result);

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", n_cycles);
            $display("[i2c_master_bit_engine] ERROR");
            $finish;
        end
    end

    function automatic req_t rand_item();
        req_t r;
        r.req_type   = 1'($urandom_range(1));
        r.command    = 3'($urandom_range(CMD_CODE_MAX));
        r.write_data = 8'($urandom_range(255));
        r.send_ack   = 1'($urandom_range(1));
        r.sda_in     = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic req_t tick_item(logic level);
        req_t r;
        r          = rand_item();
        r.req_type = 1'b0;
        r.sda_in   = level;
        return r;
    endfunction

    // what the target puts on SDA for the next tick
    function automatic logic line_bit();
        if (mdl.ph == PH_WA_POLL)
            return slave_gone ? 1'b1 : ($urandom_range(2) == 0);
        case (line_mode)
            LINE_HIGH: return 1'b1;
            LINE_LOW:  return 1'b0;
            default:   return 1'($urandom_range(1));
        endcase
    endfunction

    task automatic set_mode(int m);
        case (m)
            0:       begin send_idle = 38; recv_idle = 88; end
            1:       begin send_idle = 88; recv_idle = 38; end
            default: begin send_idle = 0;  recv_idle = 0;  end
        endcase
    endtask

    task automatic send_item(req_t r);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= r;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        mdl.take_item(r);
    endtask

    task automatic send_cmd(logic [2:0] c, logic [7:0] d, logic a);
        req_t r;
        r            = rand_item();
        r.req_type   = 1'b1;
        r.command    = c;
        r.write_data = d;
        r.send_ack   = a;
        send_item(r);
    endtask

    // tick until the current command is over; noisy slips in stray items
    task automatic run_ticks(bit noisy);
        while (mdl.ph != PH_IDLE)
        begin
            if (noisy && $urandom_range(49) == 0)
                send_item(rand_item());
            else
                send_item(tick_item(line_bit()));
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (mdl.pending_res.size() != 0);
    endtask

    task automatic apb_access(logic [2:0] idx, logic wr, logic [31:0] d,
                              output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        if (wr)
            mdl.set_reg(idx, d);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] d);
        logic [31:0] unused_rd;
        apb_access(idx, 1'b1, d, unused_rd);
    endtask

    task automatic check_regs();
        logic [31:0] got;
        for (int i = REG_SLAVE_ADDR; i <= REG_ACK_TIMEOUT; i++)
        begin
            apb_access(3'(i), 1'b0, '0, got);
            mdl.cmp($sformatf("register %0d readback", i), got, mdl.reg_value(3'(i)));
        end
    endtask

    task automatic load_settings(logic [31:0] addr, logic [31:0] setup, logic [31:0] half,
                                 logic [31:0] settle, logic [31:0] tmo);
        drain();
        reg_write(REG_SLAVE_ADDR, addr);
        reg_write(REG_SETUP, setup);
        reg_write(REG_BIT_HALF, half);
        reg_write(REG_ACK_SETTLE, settle);
        reg_write(REG_ACK_TIMEOUT, tmo);
        check_regs();
    endtask

    task automatic run_transfer(bit gone);
        logic [2:0] start;
        int         nbytes;
        slave_gone = gone;
        line_mode  = LINE_RANDOM;
        start      = $urandom_range(1) ? CMD_START_RD : CMD_START_WR;
        nbytes     = $urandom_range(1, 3);
        send_cmd(start, 8'($urandom_range(255)), 1'($urandom_range(1)));
        run_ticks(1'b1);
        for (int i = 0; i < nbytes && !mdl.last_fail; i++)
        begin
            if (start == CMD_START_WR)
                send_cmd(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            else
                send_cmd(CMD_READ, 8'($urandom_range(255)), i != nbytes - 1);
            run_ticks(1'b1);
        end
        if (!mdl.last_fail)
        begin
            send_cmd(CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
            run_ticks(1'b1);
        end
        slave_gone = 1'b0;
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            send_item(rand_item());
    endtask

    initial
    begin
        int stop_at;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, address 127
        set_mode(0);
        send_item(tick_item(1'b0));
        for (int c = CMD_STOP + 1; c <= CMD_CODE_MAX; c++)
            send_cmd(3'(c), 8'hA5, 1'b1);
        send_cmd(CMD_START_WR, 8'h00, 1'b0);
        send_item(tick_item(1'b1));
        send_cmd(CMD_READ, 8'h00, 1'b1);
        run_ticks(1'b0);
        send_cmd(CMD_WRITE, 8'hFF, 1'b0);
        run_ticks(1'b0);
        send_cmd(CMD_WRITE, 8'h00, 1'b1);
        run_ticks(1'b0);
        send_cmd(CMD_STOP, 8'h00, 1'b0);
        run_ticks(1'b0);
        send_cmd(CMD_START_RD, 8'hFF, 1'b1);
        run_ticks(1'b0);
        line_mode = LINE_HIGH;
        send_cmd(CMD_READ, 8'h00, 1'b1);
        run_ticks(1'b0);
        line_mode = LINE_LOW;
        send_cmd(CMD_READ, 8'hFF, 1'b0);
        run_ticks(1'b0);
        line_mode = LINE_RANDOM;
        send_cmd(CMD_STOP, 8'hFF, 1'b1);
        run_ticks(1'b0);

        // bit timing changed while a byte is under way
        send_cmd(CMD_WRITE, 8'h5A, 1'b0);
        repeat (3)
            send_item(tick_item(line_bit()));
        drain();
        reg_write(REG_BIT_HALF, 32'd1);
        run_ticks(1'b0);

        // target never acks: full reset-value timeout, then automatic stop
        slave_gone = 1'b1;
        send_cmd(CMD_START_WR, 8'h00, 1'b0);
        run_ticks(1'b0);
        slave_gone = 1'b0;

        drain();
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        reg_write(REG_LAST_CODE, 32'h0000_0003);
        check_regs();

        // zero delays and zero timeout; address write carries junk upper bits
        load_settings(32'hFFFF_FF80, 32'd0, 32'd0, 32'd0, 32'd0);
        run_transfer(1'b0);
        run_transfer(1'b1);

        for (int m = 0; m < 3; m++)
        begin
            set_mode(m);
            for (int s = 0; s < 2; s++)
            begin
                if (m == 0 && s == 0)
                    load_settings(32'd0, 32'd1, 32'd1, 32'd1, 32'd1);
                else if (m == 1 && s == 0)
                    load_settings(32'd127, 32'd1, 32'd2, 32'd1, 32'd255);
                else
                    load_settings($urandom_range(127), $urandom_range(1, 3),
                                  $urandom_range(1, 3), $urandom_range(1, 3),
                                  $urandom_range(0, 6));
                stop_at = mdl.n_live + RAND_ITEMS_PER_SET;
                while (mdl.n_live < stop_at)
                begin
                    if ($urandom_range(99) < 85)
                        run_transfer($urandom_range(9) == 0);
                    else
                    begin
                        send_noise();
                        run_ticks(1'b1);
                    end
                    // hold off until every outstanding beat is back
                    if ($urandom_range(9) == 0)
                        drain();
                end
            end
        end

        // widest delays and timeout: one failed address phase, one plain stop
        load_settings(32'h55, 32'd255, 32'd255, 32'd255, 32'd255);
        run_transfer(1'b1);
        send_cmd(CMD_STOP, 8'h00, 1'b0);
        run_ticks(1'b0);

        drain();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("covered %0d effective items over reset, zero, min, random and max timing",
                 mdl.n_live);
        $display("%0d result beats checked, %0d commands done, %0d without ack, %0d rejected",
                 mdl.n_checked, mdl.n_done, mdl.n_noack, mdl.n_rej);
        if (mdl.n_err == 0)
            $display("[i2c_master_bit_engine] OK");
        else
            $display("[i2c_master_bit_engine] ERROR");
        $finish;
    end

endmodule
